@@ rtl/uhx_pkg.sv @@
package uhx_pkg;

  localparam logic [7:0] UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_A_LOWER = 8'h61;
  localparam logic [7:0] CHAR_F_LOWER = 8'h66;
  localparam int unsigned MAX_EMIT = 4;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_ONE,
    MODE_TWO,
    MODE_DIGIT
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       name_end;
  } out_beat_t;

  // Decoded bytes of one input beat, in output order from entry zero.
  typedef struct packed {
    logic [MAX_EMIT-1:0][7:0] bytes;
    logic [2:0]               count;
    logic                     fin;
  } uhx_emit_t;

  function automatic logic is_hex(input logic [7:0] b);
    return ((b >= CHAR_ZERO) && (b <= CHAR_NINE)) ||
           ((b >= CHAR_A_LOWER) && (b <= CHAR_F_LOWER));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    if ((b >= CHAR_ZERO) && (b <= CHAR_NINE)) begin
      v = b - CHAR_ZERO;
    end else if ((b >= CHAR_A_LOWER) && (b <= CHAR_F_LOWER)) begin
      v = b - CHAR_A_LOWER + 8'd10;
    end else begin
      v = 8'd0;
    end
    return v[3:0];
  endfunction

endpackage

@@ rtl/underscore_hex_escape_decoder_core.sv @@
// Decodes an underscore-escaped name one byte per beat. A double underscore followed by a
// third underscore gives a literal double underscore, followed by two lowercase hex digits
// gives the byte they spell, and followed by anything else is passed on unchanged. Each input
// beat is decoded in the cycle it is accepted into a small output buffer of up to four beats,
// which drains one beat per cycle while out_ready is high; a new input beat is taken in the
// same cycle as the last buffered beat leaves, so plain bytes stream at one per cycle while
// out_ready is high. A beat that breaks an escape or ends a name may produce two to four
// output beats and holds the input until all but the last have left; beats that only open an
// escape produce nothing. run_end marks the last output of each input beat, name_end of a name.
module underscore_hex_escape_decoder_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  uhx_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_ready,
  output uhx_pkg::out_beat_t out_beat
);
  import uhx_pkg::*;

  uhx_emit_t emit;
  logic      in_accept;

  assign in_accept = in_valid && in_ready;

  uhx_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_beat   (in_beat),
    .emit      (emit)
  );

  uhx_emit_buf u_emit_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (in_accept),
    .emit      (emit),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

endmodule

@@ rtl/uhx_scan.sv @@
module uhx_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_accept,
  input  uhx_pkg::in_beat_t in_beat,
  output uhx_pkg::uhx_emit_t emit
);
  import uhx_pkg::*;

  scan_mode_t scan_mode;
  scan_mode_t scan_mode_next;
  scan_mode_t step_mode;
  logic [7:0] held_digit;
  logic [7:0] held_digit_next;
  logic [7:0] b;
  logic       fin;

  assign b = in_beat.in_byte;
  assign fin = in_beat.is_final;

  always_comb begin
    step_mode = MODE_IDLE;
    held_digit_next = held_digit;
    unique case (scan_mode)
      MODE_IDLE: begin
        step_mode = (b == UNDERSCORE) ? MODE_ONE : MODE_IDLE;
      end
      MODE_ONE: begin
        step_mode = (b == UNDERSCORE) ? MODE_TWO : MODE_IDLE;
      end
      MODE_TWO: begin
        if (b == UNDERSCORE) begin
          step_mode = MODE_IDLE;
        end else if (is_hex(b)) begin
          step_mode = MODE_DIGIT;
          held_digit_next = b;
        end else begin
          step_mode = MODE_IDLE;
        end
      end
      MODE_DIGIT: begin
        if (is_hex(b)) begin
          step_mode = MODE_IDLE;
        end else begin
          step_mode = (b == UNDERSCORE) ? MODE_ONE : MODE_IDLE;
        end
        held_digit_next = 8'd0;
      end
      default: step_mode = MODE_IDLE;
    endcase
    scan_mode_next = step_mode;
    if (fin) begin
      scan_mode_next = MODE_IDLE;
      held_digit_next = 8'd0;
    end
  end

  always_comb begin
    emit = '0;
    emit.fin = fin;
    unique case (scan_mode)
      MODE_IDLE: begin
        if (b != UNDERSCORE) begin
          emit.bytes[emit.count[1:0]] = b;
          emit.count = emit.count + 3'd1;
        end
      end
      MODE_ONE: begin
        if (b != UNDERSCORE) begin
          emit.bytes[emit.count[1:0]] = UNDERSCORE;
          emit.count = emit.count + 3'd1;
          emit.bytes[emit.count[1:0]] = b;
          emit.count = emit.count + 3'd1;
        end
      end
      MODE_TWO: begin
        if (b == UNDERSCORE) begin
          emit.bytes[emit.count[1:0]] = UNDERSCORE;
          emit.count = emit.count + 3'd1;
          emit.bytes[emit.count[1:0]] = UNDERSCORE;
          emit.count = emit.count + 3'd1;
        end else if (!is_hex(b)) begin
          emit.bytes[emit.count[1:0]] = UNDERSCORE;
          emit.count = emit.count + 3'd1;
          emit.bytes[emit.count[1:0]] = UNDERSCORE;
          emit.count = emit.count + 3'd1;
          emit.bytes[emit.count[1:0]] = b;
          emit.count = emit.count + 3'd1;
        end
      end
      MODE_DIGIT: begin
        if (is_hex(b)) begin
          emit.bytes[emit.count[1:0]] = {hex_val(held_digit), hex_val(b)};
          emit.count = emit.count + 3'd1;
        end else begin
          emit.bytes[emit.count[1:0]] = UNDERSCORE;
          emit.count = emit.count + 3'd1;
          emit.bytes[emit.count[1:0]] = UNDERSCORE;
          emit.count = emit.count + 3'd1;
          emit.bytes[emit.count[1:0]] = held_digit;
          emit.count = emit.count + 3'd1;
          if (b != UNDERSCORE) begin
            emit.bytes[emit.count[1:0]] = b;
            emit.count = emit.count + 3'd1;
          end
        end
      end
      default: emit.count = 3'd0;
    endcase
    // On the last beat of a name, whatever is still held is flushed unchanged.
    if (fin) begin
      unique case (step_mode)
        MODE_IDLE: begin
          emit.count = emit.count;
        end
        MODE_ONE: begin
          emit.bytes[emit.count[1:0]] = UNDERSCORE;
          emit.count = emit.count + 3'd1;
        end
        MODE_TWO: begin
          emit.bytes[emit.count[1:0]] = UNDERSCORE;
          emit.count = emit.count + 3'd1;
          emit.bytes[emit.count[1:0]] = UNDERSCORE;
          emit.count = emit.count + 3'd1;
        end
        MODE_DIGIT: begin
          emit.bytes[emit.count[1:0]] = UNDERSCORE;
          emit.count = emit.count + 3'd1;
          emit.bytes[emit.count[1:0]] = UNDERSCORE;
          emit.count = emit.count + 3'd1;
          emit.bytes[emit.count[1:0]] = b;
          emit.count = emit.count + 3'd1;
        end
        default: emit.count = emit.count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= MODE_IDLE;
      held_digit <= 8'd0;
    end else if (in_accept) begin
      scan_mode <= scan_mode_next;
      held_digit <= held_digit_next;
    end
  end

  a_final_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (in_accept && fin) |=> (scan_mode == MODE_IDLE))
    else $error("scan mode not idle after the last beat of a name");

  a_final_emits: assert property (@(posedge clk) disable iff (rst)
    (in_accept && fin) |-> (emit.count != 3'd0))
    else $error("last beat of a name produced no output");

  a_digit_held: assert property (@(posedge clk) disable iff (rst)
    (scan_mode == MODE_DIGIT) |-> is_hex(held_digit))
    else $error("held digit is not a hex digit");

endmodule

@@ rtl/uhx_emit_buf.sv @@
module uhx_emit_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  uhx_pkg::uhx_emit_t emit,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output uhx_pkg::out_beat_t out_beat
);
  import uhx_pkg::*;

  logic [MAX_EMIT-1:0][7:0] bytes;
  logic [2:0]               remain;
  logic [1:0]               idx;
  logic                     fin;
  logic                     drain;

  assign out_valid = (remain != 3'd0);
  assign drain = out_valid && out_ready;
  assign in_ready = (remain == 3'd0) || ((remain == 3'd1) && out_ready);

  assign out_beat.out_byte = bytes[idx];
  assign out_beat.run_end = (remain == 3'd1);
  assign out_beat.name_end = (remain == 3'd1) && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= 3'd0;
      idx <= 2'd0;
    end else if (load) begin
      remain <= emit.count;
      idx <= 2'd0;
    end else if (drain) begin
      remain <= remain - 3'd1;
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= emit.bytes;
      fin <= emit.fin;
    end
  end

  a_remain_bound: assert property (@(posedge clk) disable iff (rst)
    remain <= 3'(MAX_EMIT))
    else $error("output buffer holds more beats than it has entries");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, idx} + remain) <= 3'(MAX_EMIT))
    else $error("read index runs past the buffered beats");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (drain && (remain == 3'd1) && !load) |=> !out_valid)
    else $error("buffer not empty after its last beat was taken");

endmodule

@@ dv/tb_underscore_hex_escape_decoder_core.sv @@
module tb_underscore_hex_escape_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import uhx_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned RANDOM_BEATS = 450;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned DIR_N = 27;

  // One row of the directed table. Where typed is set, cnt and bytes give the decoded
  // output of this beat, first byte in the top eight bits.
  typedef struct packed {
    logic [7:0]  ch;
    logic        fin;
    logic        typed;
    logic [2:0]  cnt;
    logic [31:0] bytes;
  } row_t;

  localparam row_t DIRECTED [DIR_N] = '{
    '{8'h41,      1'b0, 1'b1, 3'd1, 32'h41000000},
    '{8'h00,      1'b0, 1'b1, 3'd1, 32'h00000000},
    '{8'hFF,      1'b1, 1'b1, 3'd1, 32'hFF000000},
    '{UNDERSCORE, 1'b0, 1'b1, 3'd0, 32'h0},
    '{UNDERSCORE, 1'b0, 1'b1, 3'd0, 32'h0},
    '{UNDERSCORE, 1'b0, 1'b1, 3'd2, 32'h5F5F0000},
    '{UNDERSCORE, 1'b0, 1'b1, 3'd0, 32'h0},
    '{UNDERSCORE, 1'b0, 1'b1, 3'd0, 32'h0},
    '{CHAR_ZERO,  1'b0, 1'b1, 3'd0, 32'h0},
    '{CHAR_ZERO,  1'b0, 1'b1, 3'd1, 32'h00000000},
    '{UNDERSCORE, 1'b0, 1'b1, 3'd0, 32'h0},
    '{UNDERSCORE, 1'b0, 1'b1, 3'd0, 32'h0},
    '{8'h66,      1'b0, 1'b1, 3'd0, 32'h0},
    '{8'h46,      1'b0, 1'b0, 3'd0, 32'h0},
    '{UNDERSCORE, 1'b0, 1'b1, 3'd0, 32'h0},
    '{UNDERSCORE, 1'b0, 1'b1, 3'd0, 32'h0},
    '{8'h41,      1'b0, 1'b1, 3'd3, 32'h5F5F4100},
    '{UNDERSCORE, 1'b0, 1'b1, 3'd0, 32'h0},
    '{UNDERSCORE, 1'b0, 1'b1, 3'd0, 32'h0},
    '{CHAR_NINE,  1'b0, 1'b1, 3'd0, 32'h0},
    '{UNDERSCORE, 1'b1, 1'b0, 3'd0, 32'h0},
    '{UNDERSCORE, 1'b0, 1'b1, 3'd0, 32'h0},
    '{UNDERSCORE, 1'b1, 1'b1, 3'd2, 32'h5F5F0000},
    '{UNDERSCORE, 1'b0, 1'b1, 3'd0, 32'h0},
    '{UNDERSCORE, 1'b0, 1'b1, 3'd0, 32'h0},
    '{8'h33,      1'b1, 1'b1, 3'd3, 32'h5F5F3300},
    '{UNDERSCORE, 1'b1, 1'b1, 3'd1, 32'h5F000000}
  };

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_beat;

  underscore_hex_escape_decoder_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  scan_mode_t  esc_mode;
  logic [7:0]  esc_digit;
  logic [7:0]  step_chars [MAX_EMIT];
  int unsigned step_count;

  out_beat_t   decoded_q [$];
  row_t        beat_notes [$];
  logic [7:0]  name_chars [$];

  int unsigned errors;
  int unsigned in_beats;
  int unsigned out_beats;
  int unsigned names_closed;
  int unsigned hex_escapes;
  int unsigned cycle_count;
  int unsigned tx_free;
  logic        rx_hold;

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Top bit flags a lowercase hex digit, the low four bits hold its value.
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      return {1'b1, c[3:0]};
    end else if (c >= CHAR_A_LOWER && c <= CHAR_F_LOWER) begin
      return {1'b1, c[3:0] + 4'd9};
    end
    return 5'd0;
  endfunction

  function automatic void add_char(input logic [7:0] c);
    if (step_count < MAX_EMIT) begin
      step_chars[step_count] = c;
      step_count++;
    end
  endfunction

  function automatic void restart_on(input logic [7:0] c);
    if (c == UNDERSCORE) begin
      esc_mode = MODE_ONE;
    end else begin
      esc_mode = MODE_IDLE;
      add_char(c);
    end
  endfunction

  function automatic void unescape(input in_beat_t b);
    logic [4:0] lo;
    logic [4:0] hi;
    step_count = 0;
    lo = nibble_of(b.in_byte);
    case (esc_mode)
      MODE_IDLE: begin
        restart_on(b.in_byte);
      end
      MODE_ONE: begin
        if (b.in_byte == UNDERSCORE) begin
          esc_mode = MODE_TWO;
        end else begin
          add_char(UNDERSCORE);
          restart_on(b.in_byte);
        end
      end
      MODE_TWO: begin
        if (b.in_byte == UNDERSCORE) begin
          add_char(UNDERSCORE);
          add_char(UNDERSCORE);
          esc_mode = MODE_IDLE;
        end else if (lo[4]) begin
          esc_digit = b.in_byte;
          esc_mode = MODE_DIGIT;
        end else begin
          add_char(UNDERSCORE);
          add_char(UNDERSCORE);
          restart_on(b.in_byte);
        end
      end
      default: begin
        hi = nibble_of(esc_digit);
        if (lo[4]) begin
          add_char({hi[3:0], lo[3:0]});
          esc_mode = MODE_IDLE;
          hex_escapes++;
        end else begin
          add_char(UNDERSCORE);
          add_char(UNDERSCORE);
          add_char(esc_digit);
          restart_on(b.in_byte);
        end
        esc_digit = 8'h00;
      end
    endcase
    if (b.is_final) begin
      if (esc_mode == MODE_ONE) begin
        add_char(UNDERSCORE);
      end else if (esc_mode == MODE_TWO) begin
        add_char(UNDERSCORE);
        add_char(UNDERSCORE);
      end else if (esc_mode == MODE_DIGIT) begin
        add_char(UNDERSCORE);
        add_char(UNDERSCORE);
        add_char(esc_digit);
      end
      esc_mode = MODE_IDLE;
      esc_digit = 8'h00;
    end
  endfunction

  task automatic accept_beat(input in_beat_t b);
    row_t      note;
    out_beat_t ob;
    note = '0;
    if (beat_notes.size() != 0) begin
      note = beat_notes.pop_front();
    end
    in_beats++;
    unescape(b);
    if (note.typed) begin
      step_count = note.cnt;
      for (int k = 0; k < MAX_EMIT; k++) begin
        step_chars[k] = note.bytes[31 - 8 * k -: 8];
      end
    end
    for (int unsigned k = 0; k < step_count; k++) begin
      ob.out_byte = step_chars[k];
      ob.run_end = (k == step_count - 1);
      ob.name_end = (k == step_count - 1) && b.is_final;
      decoded_q.push_back(ob);
    end
  endtask

  task automatic report_mismatch(input string what, input out_beat_t exp_b,
                                 input out_beat_t got_b);
    errors++;
    if (errors <= 10) begin
      $write("%0t %s: expected byte %02h run_end %0b name_end %0b, ",
             $time, what, exp_b.out_byte, exp_b.run_end, exp_b.name_end);
      $display("got byte %02h run_end %0b name_end %0b",
               got_b.out_byte, got_b.run_end, got_b.name_end);
    end
  endtask

  task automatic check_beat(input out_beat_t got_b);
    out_beat_t exp_b;
    out_beats++;
    if (got_b.name_end === 1'b1) begin
      names_closed++;
    end
    if (decoded_q.size() == 0) begin
      report_mismatch("output beat with nothing expected", 'x, got_b);
    end else begin
      exp_b = decoded_q.pop_front();
      if (got_b.out_byte !== exp_b.out_byte || got_b.run_end !== exp_b.run_end ||
          got_b.name_end !== exp_b.name_end) begin
        report_mismatch("output beat mismatch", exp_b, got_b);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        accept_beat(in_beat);
      end
      if (out_valid && out_ready) begin
        check_beat(out_beat);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d beats outstanding.", cycle_count,
               decoded_q.size());
      $display("underscore_hex_escape_decoder_core verification failed");
      $finish;
    end
  end

  // The receiver stalls at random, with long stretches of readiness, and holds off
  // completely when the sender asks for it.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned free_left;
    int unsigned gap;
    stall_left = 0;
    free_left = 0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (free_left > 0) begin
        out_ready <= 1'b1;
        free_left--;
      end else if ($urandom_range(0, 9) == 0) begin
        out_ready <= 1'b1;
        free_left = $urandom_range(20, 60);
      end else begin
        gap = pick_gap();
        out_ready <= (gap == 0);
        stall_left = (gap > 0) ? gap - 1 : 0;
      end
      @(negedge clk);
    end
  end

  // Entered and left at a falling edge. On return, valid is still high with the accepted
  // payload, so the caller either presents the next beat or lowers valid.
  task automatic send_char(input logic [7:0] c, input logic fin, input row_t note);
    int unsigned gap;
    if (tx_free > 0) begin
      gap = 0;
      tx_free--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 9) == 0) begin
        tx_free = $urandom_range(20, 60);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    beat_notes.push_back(note);
    in_valid <= 1'b1;
    in_beat <= '{in_byte: c, is_final: fin};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_hex_char();
    int unsigned v;
    v = $urandom_range(0, 15);
    return (v < 10) ? CHAR_ZERO + 8'(v) : CHAR_A_LOWER + 8'(v - 10);
  endfunction

  function automatic logic [7:0] rand_non_hex(input logic allow_underscore);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (nibble_of(c) != 5'd0 || (!allow_underscore && c == UNDERSCORE));
    return c;
  endfunction

  function automatic void push_pair();
    name_chars.push_back(UNDERSCORE);
    name_chars.push_back(UNDERSCORE);
  endfunction

  // Builds one name from random plain bytes and escape sequences, sometimes cut off
  // part way through an escape at its end.
  function automatic void build_name();
    int unsigned tokens;
    int unsigned r;
    name_chars.delete();
    tokens = $urandom_range(1, 6);
    for (int unsigned t = 0; t < tokens; t++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        name_chars.push_back(8'($urandom_range(0, 255)));
      end else if (r < 60) begin
        push_pair();
        name_chars.push_back(rand_hex_char());
        name_chars.push_back(rand_hex_char());
      end else if (r < 70) begin
        push_pair();
        name_chars.push_back(UNDERSCORE);
      end else if (r < 78) begin
        push_pair();
        name_chars.push_back(8'h41 + 8'($urandom_range(0, 5)));
      end else if (r < 86) begin
        push_pair();
        name_chars.push_back(rand_hex_char());
        name_chars.push_back(rand_non_hex(1'b1));
      end else if (r < 92) begin
        push_pair();
        name_chars.push_back(rand_non_hex(1'b0));
      end else begin
        name_chars.push_back(UNDERSCORE);
        name_chars.push_back(8'($urandom_range(0, 255)));
      end
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      name_chars.push_back(UNDERSCORE);
    end else if (r < 10) begin
      push_pair();
    end else if (r < 15) begin
      push_pair();
      name_chars.push_back(rand_hex_char());
    end
  endfunction

  initial begin : stimulus
    int unsigned random_sent;
    logic        hold_done;
    logic        pause_done;
    rst = 1'b1;
    in_valid = 1'b0;
    in_beat = '0;
    rx_hold = 1'b0;
    tx_free = 0;
    errors = 0;
    in_beats = 0;
    out_beats = 0;
    names_closed = 0;
    hex_escapes = 0;
    cycle_count = 0;
    esc_mode = MODE_IDLE;
    esc_digit = 8'h00;
    random_sent = 0;
    hold_done = 1'b0;
    pause_done = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) begin
      send_char(DIRECTED[i].ch, DIRECTED[i].fin, DIRECTED[i]);
    end

    while (random_sent < RANDOM_BEATS) begin
      if (!hold_done && random_sent >= 80) begin
        rx_hold = 1'b1;
        hold_done = 1'b1;
        tx_free = 40;
      end
      if (!pause_done && random_sent >= 250) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (decoded_q.size() != 0) @(negedge clk);
        pause_done = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), '0);
        random_sent++;
      end else begin
        build_name();
        foreach (name_chars[k]) begin
          send_char(name_chars[k], k == name_chars.size() - 1, '0);
          random_sent++;
        end
      end
    end
    in_valid <= 1'b0;

    while (decoded_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (decoded_q.size() != 0) begin
      errors++;
      $display("%0d expected output beats never arrived.", decoded_q.size());
    end

    $display("Run covered %0d input beats (%0d from the directed table) and %0d output beats.",
             in_beats, DIR_N, out_beats);
    $display("Hex escapes decoded: %0d, names closed: %0d, mismatches: %0d.",
             hex_escapes, names_closed, errors);
    if (errors == 0) begin
      $display("underscore_hex_escape_decoder_core verification clean");
    end else begin
      $display("underscore_hex_escape_decoder_core verification failed");
    end
    $finish;
  end

endmodule
